### rtl/hrgb_pkg.sv
// Shared types, constants and the scale8 helper for the rainbow HSV to RGB converter.
// Used by every stage module and the top level; depends on nothing.
package hrgb_pkg;

  localparam logic [7:0] FULL_SCALE   = 8'd255;
  localparam logic [7:0] THIRD        = 8'd85;
  localparam logic [7:0] DOUBLE_THIRD = 8'd170;
  localparam logic [7:0] THIRD_HIGH   = 8'd171;
  localparam logic [4:0] FRAC_MASK    = 5'h1F;

  typedef enum logic [2:0] {
    SEC_RED    = 3'd0,
    SEC_ORANGE = 3'd1,
    SEC_YELLOW = 3'd2,
    SEC_GREEN  = 3'd3,
    SEC_AQUA   = 3'd4,
    SEC_BLUE   = 3'd5,
    SEC_PURPLE = 3'd6,
    SEC_PINK   = 3'd7
  } sector_t;

  typedef struct packed {
    logic       valid;
    sector_t    sector;
    logic [7:0] t1;
    logic [7:0] t2;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] wash;
  } front_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] val;
    logic [7:0] wash;
  } mix_t;

  function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
    logic [16:0] prod;
    prod = 17'(a) * 17'({1'b0, b} + 9'd1);
    return prod[15:8];
  endfunction

endpackage

### rtl/hrgb_front.sv
// First stage: sector, the one-third and double-third offsets, and the desaturation square.
// Depends on hrgb_pkg.
module hrgb_front
  import hrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic [7:0] hue,
  input  logic [7:0] sat,
  input  logic [7:0] val,
  output front_t     stage
);

  front_t     stage_r;
  front_t     stage_nxt;
  logic [7:0] frac;
  logic [7:0] desat;

  always_comb begin
    frac             = {hue[4:0] & FRAC_MASK, 3'b000};
    desat            = FULL_SCALE - sat;
    stage_nxt.valid  = load;
    stage_nxt.sector = sector_t'(hue[7:5]);
    stage_nxt.t1     = scale8(frac, THIRD);
    stage_nxt.t2     = scale8(frac, DOUBLE_THIRD);
    stage_nxt.sat    = sat;
    stage_nxt.val    = val;
    stage_nxt.wash   = scale8(desat, desat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.sector <= stage_nxt.sector;
    stage_r.t1     <= stage_nxt.t1;
    stage_r.t2     <= stage_nxt.t2;
    stage_r.sat    <= stage_nxt.sat;
    stage_r.val    <= stage_nxt.val;
    stage_r.wash   <= stage_nxt.wash;
  end

  assign stage = stage_r;

endmodule

### rtl/hrgb_mix.sv
// Second stage: base color from the sector, then each channel scaled by saturation.
// Depends on hrgb_pkg.
module hrgb_mix
  import hrgb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  front_t front,
  output mix_t   stage
);

  mix_t       stage_r;
  mix_t       stage_nxt;
  logic [7:0] base_r;
  logic [7:0] base_g;
  logic [7:0] base_b;

  always_comb begin
    unique case (front.sector)
      SEC_RED: begin
        base_r = FULL_SCALE - front.t1;  base_g = front.t1;
        base_b = 8'd0;
      end
      SEC_ORANGE: begin
        base_r = THIRD_HIGH;  base_g = THIRD + front.t1;
        base_b = 8'd0;
      end
      SEC_YELLOW: begin
        base_r = THIRD_HIGH - front.t2;  base_g = DOUBLE_THIRD + front.t1;
        base_b = 8'd0;
      end
      SEC_GREEN: begin
        base_r = 8'd0;  base_g = FULL_SCALE - front.t1;
        base_b = front.t1;
      end
      SEC_AQUA: begin
        base_r = 8'd0;  base_g = THIRD_HIGH - front.t2;
        base_b = THIRD + front.t2;
      end
      SEC_BLUE: begin
        base_r = front.t1;  base_g = 8'd0;
        base_b = FULL_SCALE - front.t1;
      end
      SEC_PURPLE: begin
        base_r = THIRD + front.t1;  base_g = 8'd0;
        base_b = THIRD_HIGH - front.t1;
      end
      SEC_PINK: begin
        base_r = DOUBLE_THIRD + front.t1;  base_g = 8'd0;
        base_b = THIRD - front.t1;
      end
      default: begin
        base_r = 8'd0;  base_g = 8'd0;
        base_b = 8'd0;
      end
    endcase
    stage_nxt.valid = front.valid;
    stage_nxt.red   = scale8(base_r, front.sat);
    stage_nxt.green = scale8(base_g, front.sat);
    stage_nxt.blue  = scale8(base_b, front.sat);
    stage_nxt.val   = front.val;
    stage_nxt.wash  = front.wash;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.red   <= stage_nxt.red;
    stage_r.green <= stage_nxt.green;
    stage_r.blue  <= stage_nxt.blue;
    stage_r.val   <= stage_nxt.val;
    stage_r.wash  <= stage_nxt.wash;
  end

  assign stage = stage_r;

endmodule

### rtl/hrgb_finish.sv
// Last stage: adds the white wash with saturation at full scale, then scales by value.
// Depends on hrgb_pkg; drives the registered result of the converter.
module hrgb_finish
  import hrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mix_t       mix,
  output logic       valid,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic       valid_r;
  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;
  logic [7:0] red_nxt;
  logic [7:0] green_nxt;
  logic [7:0] blue_nxt;
  logic [8:0] sum_r;
  logic [8:0] sum_g;
  logic [8:0] sum_b;
  logic [7:0] sat_r;
  logic [7:0] sat_g;
  logic [7:0] sat_b;

  always_comb begin
    sum_r     = {1'b0, mix.red} + {1'b0, mix.wash};
    sum_g     = {1'b0, mix.green} + {1'b0, mix.wash};
    sum_b     = {1'b0, mix.blue} + {1'b0, mix.wash};
    sat_r     = sum_r[8] ? FULL_SCALE : sum_r[7:0];
    sat_g     = sum_g[8] ? FULL_SCALE : sum_g[7:0];
    sat_b     = sum_b[8] ? FULL_SCALE : sum_b[7:0];
    red_nxt   = scale8(sat_r, mix.val);
    green_nxt = scale8(sat_g, mix.val);
    blue_nxt  = scale8(sat_b, mix.val);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= mix.valid;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign valid = valid_r;
  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

### rtl/hsv_rainbow_to_rgb.sv
// Top level of the rainbow HSV to RGB converter.
// Instantiates hrgb_front, hrgb_mix and hrgb_finish; depends on hrgb_pkg.
//
// The converter takes one item per clock: busy never rises, so every cycle with
// start high loads an item. Each item passes three register stages (offsets and
// desaturation square, sector color and saturation scale, white wash and value
// scale), and its result appears on the out_ ports with out_valid high for exactly
// one cycle. The receiver cannot stall the pipeline, so it must take every result
// in the cycle it is shown.
module hsv_rainbow_to_rgb
  import hrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_hue,
  input  logic [7:0] in_saturation,
  input  logic [7:0] in_brightness,
  output logic       out_valid,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  front_t front;
  mix_t   mix;

  assign busy = 1'b0;

  hrgb_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (start & ~busy),
    .hue   (in_hue),
    .sat   (in_saturation),
    .val   (in_brightness),
    .stage (front)
  );

  hrgb_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .front (front),
    .stage (mix)
  );

  hrgb_finish u_finish (
    .clk   (clk),
    .rst_n (rst_n),
    .mix   (mix),
    .valid (out_valid),
    .red   (out_red),
    .green (out_green),
    .blue  (out_blue)
  );

endmodule
